@@ rtl/sm3_hash_engine_unit_macros.svh @@
// assertion helpers for the sm3 engine
`ifndef SM3_HASH_ENGINE_UNIT_MACROS_SVH
`define SM3_HASH_ENGINE_UNIT_MACROS_SVH
// property that holds outside reset
`define SM3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property that also holds during reset
`define SM3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/sm3_pkg.sv @@
// ----------------------------------------------------------------------------
// sm3_pkg
// shared types, constants and round functions of the sm3 hash engine
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam int WordW = 32;
  localparam int QueueDepthDefault = 4;

  localparam logic [WordW-1:0] T_LOW  = 32'h79CC4519;
  localparam logic [WordW-1:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]       PAD_BYTE = 8'h80;

  // command codes from front to back
  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_LAST = 2'd1;

  typedef logic [WordW-1:0] word_t;

  // one queued command: a word to push and how the message ends
  typedef struct packed {
    logic [1:0] cmd;
    word_t      data;
    logic [2:0] nbytes;
  } cmd_t;

  function automatic word_t iv_word(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0: r = 32'h7380166F;
      3'd1: r = 32'h4914B2B9;
      3'd2: r = 32'h172442D7;
      3'd3: r = 32'hDA8A0600;
      3'd4: r = 32'hA96F30BC;
      3'd5: r = 32'h163138AA;
      3'd6: r = 32'hE38DEE4D;
      default: r = 32'hB0FB0E4E;
    endcase
    return r;
  endfunction

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [2*WordW-1:0] d;
    d = {x, x} << n;
    return d[2*WordW-1:WordW];
  endfunction

  function automatic word_t p0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t p1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

@@ rtl/sm3_front.sv @@
// ----------------------------------------------------------------------------
// sm3_front
// accepts message words and queues them as commands for the compression side
// ----------------------------------------------------------------------------
module sm3_front #(
  parameter int Depth = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       message_word,
  input  logic [2:0]        valid_bytes,
  input  logic              last_word,
  input  logic              in_valid,
  output logic              in_stall,
  output sm3_pkg::cmd_t     q_data,
  output logic              q_valid,
  input  logic              q_pop
);
  import sm3_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t            mem [Depth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            push;
  cmd_t            cmd_in;

  // classify the word
  always_comb begin
    cmd_in.data   = message_word;
    cmd_in.cmd    = last_word ? CMD_LAST : CMD_DATA;
    cmd_in.nbytes = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
  end

  assign in_stall = (count == (AW+1)'(Depth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_data   = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cmd_in;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end

endmodule

@@ rtl/sm3_back.sv @@
// ----------------------------------------------------------------------------
// sm3_back
// block buffer, padding sequencer, one-round-per-cycle compression, digest out
// ----------------------------------------------------------------------------
module sm3_back (
  input  logic              clk,
  input  logic              rst,
  input  sm3_pkg::cmd_t     q_data,
  input  logic              q_valid,
  output logic              q_pop,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              last_of_digest,
  output logic              out_valid,
  input  logic              out_stall
);
  import sm3_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_COMP  = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]  state;
  logic [2:0]  state_next;
  word_t       cv [8];
  word_t       r  [8];
  word_t       w  [16];
  logic [63:0] bit_count;
  logic [3:0]  word_pos;
  logic [5:0]  round_index;
  logic        fin;
  logic        pad_extra;
  logic        len_hi;
  logic [2:0]  out_idx;

  logic        push;
  word_t       push_val;
  logic        data_take;
  word_t       w_new;
  word_t       a12, t_j, ss1, ss2, ff, gg, tt1, tt2, wj, wj4;
  logic [63:0] cnt_next;

  // expansion: w holds w[j..j+15]
  always_comb begin
    wj    = w[0];
    wj4   = w[4];
    w_new = p1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
    a12   = rotl(r[0], 5'd12);
    t_j   = rotl((round_index < 6'd16) ? T_LOW : T_HIGH, round_index[4:0]);
    ss1   = rotl(a12 + r[4] + t_j, 5'd7);
    ss2   = ss1 ^ a12;
    if (round_index < 6'd16) begin
      ff = r[0] ^ r[1] ^ r[2];
      gg = r[4] ^ r[5] ^ r[6];
    end else begin
      ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
      gg = (r[4] & r[5]) | (~r[4] & r[6]);
    end
    tt1 = ff + r[3] + ss2 + (wj ^ wj4);
    tt2 = gg + r[7] + ss1 + wj;
  end

  // word entry: queue words in idle, padding words in pad state
  always_comb begin
    data_take = (state == S_IDLE) && q_valid;
    q_pop     = data_take;
    push      = 1'b0;
    push_val  = '0;
    cnt_next  = bit_count;
    if (data_take) begin
      if (q_data.cmd == CMD_LAST) begin
        cnt_next = bit_count + {58'd0, q_data.nbytes, 3'd0};
        push     = 1'b1;
        case (q_data.nbytes)
          3'd0: push_val = {PAD_BYTE, 24'd0};
          3'd1: push_val = {q_data.data[31:24], PAD_BYTE, 16'd0};
          3'd2: push_val = {q_data.data[31:16], PAD_BYTE, 8'd0};
          3'd3: push_val = {q_data.data[31:8], PAD_BYTE};
          default: push_val = q_data.data;
        endcase
      end else begin
        cnt_next = bit_count + 64'd32;
        push     = 1'b1;
        push_val = q_data.data;
      end
    end else if (state == S_PAD) begin
      push = 1'b1;
      if (pad_extra)                        push_val = {PAD_BYTE, 24'd0};
      else if (word_pos == 4'd14)           push_val = bit_count[63:32];
      else if (word_pos == 4'd15 && len_hi) push_val = bit_count[31:0];
      else                                  push_val = '0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (data_take) begin
        if (word_pos == 4'd15) state_next = S_COMP;
        else if (q_data.cmd == CMD_LAST) state_next = S_PAD;
      end
      S_PAD:  if (word_pos == 4'd15) state_next = S_COMP;
      S_COMP: if (round_index == 6'd63) state_next = S_FOLD;
      S_FOLD: begin
        if (fin && len_hi) state_next = S_OUT;
        else if (fin)      state_next = S_PAD;
        else               state_next = S_IDLE;
      end
      S_OUT:  if (!out_stall && out_valid && out_idx == 3'd7) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      bit_count   <= '0;
      word_pos    <= '0;
      round_index <= '0;
      fin         <= 1'b0;
      pad_extra   <= 1'b0;
      len_hi      <= 1'b0;
      out_idx     <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < 8; i++) cv[i] <= iv_word(3'(i));
    end else begin
      state <= state_next;
      if (data_take) begin
        bit_count <= cnt_next;
        if (q_data.cmd == CMD_LAST) begin
          fin       <= 1'b1;
          pad_extra <= (q_data.nbytes == 3'd4);
        end
      end
      if (push) begin
        word_pos <= word_pos + 4'd1;
        if (state == S_PAD) pad_extra <= 1'b0;
        // length goes in only once the pad byte sits at or before word 13
        if (state == S_PAD && !pad_extra && word_pos == 4'd14) len_hi <= 1'b1;
      end
      if (state == S_COMP) round_index <= round_index + 6'd1;
      if (state == S_FOLD) begin
        for (int i = 0; i < 8; i++) cv[i] <= cv[i] ^ r[i];
        if (fin && len_hi) begin
          out_valid <= 1'b1;
          out_idx   <= '0;
        end
      end
      // digest transfer
      if (state == S_OUT && out_valid && !out_stall) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == 3'd7) begin
          out_valid <= 1'b0;
          fin       <= 1'b0;
          len_hi    <= 1'b0;
          bit_count <= '0;
          for (int i = 0; i < 8; i++) cv[i] <= iv_word(3'(i));
        end
      end
    end
  end

  // block buffer shifts during rounds, fills on push
  always_ff @(posedge clk) begin
    if (push) w[word_pos] <= push_val;
    else if (state == S_COMP) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state != S_COMP) begin
      for (int i = 0; i < 8; i++) r[i] <= cv[i];
    end else begin
      r[3] <= r[2];
      r[2] <= rotl(r[1], 5'd9);
      r[1] <= r[0];
      r[0] <= tt1;
      r[7] <= r[6];
      r[6] <= rotl(r[5], 5'd19);
      r[5] <= r[4];
      r[4] <= p0(tt2);
    end
  end

  assign digest_word    = cv[out_idx];
  assign word_index     = out_idx;
  assign last_of_digest = (out_idx == 3'd7);

endmodule

@@ rtl/sm3_hash_engine_unit.sv @@
// ----------------------------------------------------------------------------
// sm3_hash_engine_unit
// streaming sm3 hash, 256-bit digest as eight 32-bit words
// ----------------------------------------------------------------------------
// Input channel: message_word/valid_bytes/last_word with in_valid, in_stall.
// Words are big-endian; last_word marks the final word, valid_bytes gives
// its leading valid bytes (0 to 4, larger values count as 4).
// Output channel: digest_word/word_index/last_of_digest with out_valid,
// out_stall; eight transfers per message, word 0 first.
// A small command queue decouples input from the compression side, so
// words keep being taken while a block compresses, until the queue fills.
// Each 16-word block is filled word by word, compressed round by round in the
// single round unit and then folded into the chaining value. The final word
// adds padding fill and one or two blocks, then the digest is presented one
// word per cycle while not stalled.
// A stalled digest word holds; compression of the next message waits.
// Reset (rst, synchronous) empties the queue and loads the initial vector.
// ----------------------------------------------------------------------------
module sm3_hash_engine_unit #(
  parameter int QueueDepth = sm3_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] message_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  input  logic        in_valid,
  output logic        in_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_of_digest,
  output logic        out_valid,
  input  logic        out_stall
);
  import sm3_pkg::*;

  cmd_t q_data;
  logic q_valid;
  logic q_pop;

  // front: accept and queue
  sm3_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .message_word, .valid_bytes, .last_word, .in_valid, .in_stall,
    .q_data, .q_valid, .q_pop
  );

  // back: pad, compress, emit
  sm3_back u_back (
    .clk, .rst, .q_data, .q_valid, .q_pop,
    .digest_word, .word_index, .last_of_digest, .out_valid, .out_stall
  );

endmodule

@@ rtl/sm3_checker.sv @@
// ----------------------------------------------------------------------------
// sm3_checker
// port-level checks of the sm3 engine
// ----------------------------------------------------------------------------
`include "sm3_hash_engine_unit_macros.svh"
module sm3_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  word_index,
  input logic        last_of_digest,
  input logic [31:0] digest_word
);
  // last flag marks index seven
  `SM3_ASSERT(a_last_idx, out_valid |-> (last_of_digest == (word_index == 3'd7)), "last flag")
  // stalled word holds
  `SM3_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(digest_word), "hold")
  // index advances by one after a transfer other than the last
  `SM3_ASSERT(a_step, out_valid && !out_stall && !last_of_digest |=>
    out_valid && word_index == $past(word_index) + 3'd1, "index step")
  // nothing out right after reset
  `SM3_ASSERT_ALWAYS(a_rst, rst |=> !out_valid, "reset")
endmodule

bind sm3_hash_engine_unit sm3_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .word_index, .last_of_digest, .digest_word
);

@@ dv/sm3_hash_engine_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_hash_engine_unit_tb
// Self-checking bench for the streaming sm3 engine. Messages of random length
// and content go in with random gaps. A built-in sm3 predictor queues the
// eight expected digest words per message, and a scoreboard compares them.
// ----------------------------------------------------------------------------
module sm3_hash_engine_unit_tb;
  import sm3_pkg::*;

  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  // sm3 predictor and expected digest store
  class digest_scoreboard;
    logic [31:0] cv[8];
    logic [31:0] blk[16];
    logic [63:0] bit_count;
    int unsigned fill;
    digest_beat_t pending[$];
    int unsigned errors;
    int unsigned digests;

    function void start_message();
      for (int i = 0; i < 8; i++) cv[i] = iv_word(3'(i));
      bit_count = '0;
      fill = 0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] w[68];
      logic [31:0] r[8];
      logic [31:0] a12, t, ss1, ss2, ff, gg, tt1, tt2, x;
      for (int j = 0; j < 16; j++) w[j] = blk[j];
      for (int j = 16; j < 68; j++) begin
        x = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
        w[j] = x ^ rol(x, 15) ^ rol(x, 23) ^ rol(w[j-13], 7) ^ w[j-6];
      end
      for (int j = 0; j < 8; j++) r[j] = cv[j];
      for (int j = 0; j < 64; j++) begin
        a12 = rol(r[0], 12);
        t = rol(j < 16 ? 32'h79CC4519 : 32'h7A879D8A, j % 32);
        ss1 = rol(a12 + r[4] + t, 7);
        ss2 = ss1 ^ a12;
        if (j < 16) begin
          ff = r[0] ^ r[1] ^ r[2];
          gg = r[4] ^ r[5] ^ r[6];
        end else begin
          ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
          gg = (r[4] & r[5]) | (~r[4] & r[6]);
        end
        tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
        tt2 = gg + r[7] + ss1 + w[j];
        r[3] = r[2];
        r[2] = rol(r[1], 9);
        r[1] = r[0];
        r[0] = tt1;
        r[7] = r[6];
        r[6] = rol(r[5], 19);
        r[5] = r[4];
        r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
      end
      for (int j = 0; j < 8; j++) cv[j] ^= r[j];
    endfunction

    function void push(logic [31:0] v);
      blk[fill] = v;
      fill++;
      if (fill == 16) begin
        compress();
        fill = 0;
      end
    endfunction

    // note one accepted input transfer
    function void note_input(logic [31:0] word, logic [2:0] nb, logic last);
      int unsigned n;
      logic [31:0] mask;
      if (!last) begin
        bit_count += 64'd32;
        push(word);
        return;
      end
      n = (nb > 4) ? 4 : nb;
      bit_count += 64'(n * 8);
      if (n == 4) begin
        push(word);
        push(32'h8000_0000);
      end else begin
        mask = (n == 0) ? 32'h0 : ~(32'hFFFF_FFFF >> (8 * n));
        push((word & mask) | (32'h80 << (24 - 8 * n)));
      end
      while (fill != 14) push('0);
      push(bit_count[63:32]);
      push(bit_count[31:0]);
      for (int i = 0; i < 8; i++) pending.push_back({cv[i], 3'(i), i == 7});
      start_message();
    endfunction

    // check one accepted output transfer
    task check_output(digest_beat_t got);
      digest_beat_t exp;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h", got.word));
        return;
      end
      exp = pending.pop_front();
      if (got.word !== exp.word)
        report_mismatch($sformatf("digest_word %h want %h", got.word, exp.word));
      if (got.index !== exp.index)
        report_mismatch($sformatf("word_index %0d want %0d", got.index, exp.index));
      if (got.last !== exp.last)
        report_mismatch($sformatf("last_of_digest %b want %b", got.last, exp.last));
      if (got.last === 1'b1) digests++;
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic [31:0] message_word = '0;
  logic [2:0]  valid_bytes = '0;
  logic        last_word = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_of_digest;
  logic        out_valid;
  logic        out_stall = 0;

  digest_scoreboard sb = new();
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;
  bit hold_off = 0;
  bit stim_done = 0;

  sm3_hash_engine_unit uut (.*);

  always #4 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    sb.errors++;
  endtask

  // one input transfer after a random gap
  task automatic send_word(logic [31:0] w, logic [2:0] nb, logic last);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    message_word <= w;
    valid_bytes <= nb;
    last_word <= last;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_input(w, nb, last);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int unsigned len, logic [2:0] nb);
    for (int i = 0; i < len; i++)
      send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
    send_word($urandom, nb, 1'b1);
  endtask

  // output side: random stall per transfer, long hold-off on request
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (600) @(negedge clk);
        hold_off = 0;
      end
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_stall <= 1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 0;
      @(negedge clk);
    end
  end

  // output monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_output({digest_word, word_index, last_of_digest});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog expired");
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    sb.start_message();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: empty message, byte counts, extreme words, block edges
    send_word('0, 3'd0, 1);
    send_word(32'h6162_6300, 3'd3, 1);
    send_word(32'hFFFF_FFFF, 3'd4, 1);
    send_word(32'hFFFF_FFFF, 3'd7, 1);
    send_word(32'h1234_5678, 3'd1, 1);
    send_word(32'h0, 3'd2, 1);
    send_message(13, 3'd4);
    send_message(14, 3'd0);
    send_message(15, 3'd3);

    // fill the block path while the receiver holds off
    hold_off = 1;
    send_message(3, 3'd2);
    send_message(20, 3'd4);

    // random messages, mostly short
    while (words_sent < 205)
      send_message(($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                               : $urandom_range(0, 15),
                   3'($urandom_range(0, 7)));
    in_valid <= 0;
    stim_done = 1;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d words, checked %0d digests incl. empty and multi-block",
             words_sent, sb.digests);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
